FILE: hdl/gpacq_pkg.sv
package gpacq_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   typedef enum logic [1:0] {
      MODE_EI   = 2'd0,
      MODE_UCB  = 2'd1,
      MODE_PI   = 2'd2,
      MODE_MEAN = 2'd3
   } mode_type;

   typedef struct packed {
      logic signed [31:0] pred_mean;
      logic [30:0]        pred_stddev;
      logic signed [31:0] best_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] score;
      logic               saturated;
   } rsp_type;

   // per-stage payload; each stage fills in what it computes
   typedef struct packed {
      mode_type           mode;
      logic               zero;
      logic               gt;
      logic               neg;
      logic signed [31:0] mu;
      logic [30:0]        sg;
      logic [31:0]        ad;
      logic               big;
      logic [32:0]        rem;
      logic [33:0]        az;
      logic [34:0]        ex;
      logic               ez;
      logic [5:0]         n;
      logic [29:0]        y;
      logic [30:0]        r;
      logic [65:0]        prod;
      logic [63:0]        aux;
      logic [28:0]        pd;
      logic [31:0]        den;
      logic [30:0]        t;
      logic signed [33:0] s;
      logic [30:0]        c;
   } pipe_type;

   // Q30 constants
   localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
   localparam logic [30:0] K_LOG2E        = 31'd1549082005;
   localparam logic [29:0] K_LN2          = 30'd744261118;
   localparam logic [28:0] K_INV_SQRT_2PI = 29'd428361012;
   localparam logic [27:0] K_P            = 28'd248723606;

   localparam logic signed [33:0] K_B5 = 34'sd1428371291;
   // added after each multiply by t, last step adds nothing
   localparam logic signed [33:0] POLY_B [5] = '{
      -34'sd1955558716, 34'sd1912847370, -34'sd382857446, 34'sd342933308, 34'sd0
   };

   // ceil(2^34 / k), exact floor division for 30-bit dividends
   localparam logic [32:0] RECIP3 = 33'd5726623062;
   localparam logic [32:0] RECIP5 = 33'd3435973837;
   localparam logic [32:0] RECIP6 = 33'd2863311531;
   localparam logic [32:0] RECIP7 = 33'd2454267027;
   localparam logic [32:0] RECIP9 = 33'd1908874354;

   function automatic logic [29:0] div_small(input logic [29:0] p, input int unsigned k);
      logic [62:0] m;
      logic [29:0] res;
      m   = '0;
      res = p;
      unique case (k)
         2: res = p >> 1;
         3: m = 63'(p) * 63'(RECIP3);
         4: res = p >> 2;
         5: m = 63'(p) * 63'(RECIP5);
         6: m = 63'(p) * 63'(RECIP6);
         7: m = 63'(p) * 63'(RECIP7);
         8: res = p >> 3;
         9: m = 63'(p) * 63'(RECIP9);
         default: res = p;
      endcase
      if (k == 3 || k == 5 || k == 6 || k == 7 || k == 9) begin
         res = 30'(m[62:34]);
      end
      return res;
   endfunction

endpackage

FILE: hdl/gp_acquisition_score_top.sv
// Gaussian-process acquisition scorer.
// Input channel (req_valid/req_ready/req_data): predicted mean, stddev and best
//   value, signed Q16.16. Result channel (rsp_valid/rsp_ready/rsp_data): score
//   and a saturation flag, one result per input transfer, in order.
// APB port: one register at byte address 0, acquisition_mode
//   (0 EI, 1 UCB, 2 PI, 3 mean). pready is tied high; writes take effect at
//   the access cycle. Change the mode only while the pipe is empty.
// Throughput: one transfer per cycle on each side while the receiver does not stall.
// The pipe length comes from the two restoring dividers (|z| = |mu-best|/sigma,
//   33 stages; t = 1/den, 31 stages) and the nine Horner steps of exp(-x),
//   two stages each.
// The whole pipe advances together when the output register is empty or is
//   being taken; when the receiver stalls, every stage holds, so nothing is
//   lost or repeated, and req_ready drops in the same cycle.
// Reset (synchronous, active high) clears all valid bits and the output
//   register's valid, and returns the mode to EI. Payload is not reset.
module gp_acquisition_score_top #(
   parameter int FRAC_BITS = gpacq_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gpacq_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gpacq_pkg::rsp_type  rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int SH = 30 - FRAC_BITS;

   // stage map
   localparam int ST_PREP   = 1;
   localparam int DIVA_LO   = 2;    // 33 quotient bits of |z|
   localparam int ST_AZ     = 35;
   localparam int ST_SQ     = 36;
   localparam int ST_EXARG  = 37;
   localparam int ST_LOGMUL = 38;
   localparam int ST_LOGSUM = 39;
   localparam int ST_LNMUL  = 40;
   localparam int ST_Y      = 41;
   localparam int HORN_LO   = 42;   // 9 steps x 2 stages
   localparam int ST_SHIFT  = 60;
   localparam int ST_PDFMUL = 61;
   localparam int ST_PDF    = 62;
   localparam int ST_DEN    = 63;
   localparam int DIVT_LO   = 64;   // 31 quotient bits of t
   localparam int ST_PINIT  = 95;
   localparam int POLY_LO   = 96;   // 5 steps x 2 stages
   localparam int ST_CDFMUL = 106;
   localparam int ST_CDF    = 107;
   localparam int ST_EIMUL  = 108;
   localparam int ST_EISUM  = 109;
   localparam int NST       = 110;

   gpacq_pkg::mode_type mode_ff, mode_in;
   gpacq_pkg::pipe_type pipe_ff [NST];
   gpacq_pkg::pipe_type pipe_in [NST];
   gpacq_pkg::pipe_type st0;
   logic [NST-1:0]      vld_ff, vld_in;
   gpacq_pkg::rsp_type  rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                adv;

   // ---------------- configuration ----------------
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {30'd0, mode_ff};

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && !paddr[2]) begin
         mode_in = gpacq_pkg::mode_type'(pwdata[1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= gpacq_pkg::MODE_EI;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // ---------------- flow control ----------------
   // whole pipe moves when the output register frees up
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   // ---------------- stage 0: difference, sign, zero sigma ----------------
   always_comb begin
      logic signed [32:0] d;
      logic [32:0]        dn;
      st0      = '0;
      d        = {req_data.pred_mean[31], req_data.pred_mean}
               - {req_data.best_value[31], req_data.best_value};
      dn       = -d;
      st0.mode = mode_ff;
      st0.mu   = req_data.pred_mean;
      st0.sg   = req_data.pred_stddev;
      st0.zero = (req_data.pred_stddev == 31'd0);
      st0.neg  = d[32];
      st0.gt   = !d[32] && (d != 33'sd0);
      st0.ad   = d[32] ? dn[31:0] : d[31:0];
   end

   assign pipe_in[0] = st0;

   // ---------------- stages 1 .. NST-1 ----------------
   for (genvar g = 1; g < NST; g++) begin : g_st
      gpacq_pkg::pipe_type nx;
      assign pipe_in[g] = nx;

      if (g == ST_PREP) begin : g_prep
         always_comb begin
            nx     = pipe_ff[g-1];
            nx.big = 34'(pipe_ff[g-1].ad) >= {pipe_ff[g-1].sg, 3'b000};
            nx.rem = 33'(pipe_ff[g-1].ad[31:3]);
            nx.az  = '0;
         end
      end else if (g >= DIVA_LO && g < ST_AZ) begin : g_diva
         localparam int BIT = 32 - (g - DIVA_LO);
         localparam int NBI = (BIT >= 30) ? BIT - 30 : 0;
         always_comb begin
            logic        nb;
            logic [32:0] trial;
            nx    = pipe_ff[g-1];
            nb    = (BIT >= 30) ? pipe_ff[g-1].ad[NBI] : 1'b0;
            trial = {pipe_ff[g-1].rem[31:0], nb};
            if (trial >= {2'b00, pipe_ff[g-1].sg}) begin
               nx.rem     = trial - {2'b00, pipe_ff[g-1].sg};
               nx.az[BIT] = 1'b1;
            end else begin
               nx.rem = trial;
            end
         end
      end else if (g == ST_AZ) begin : g_az
         always_comb begin
            nx = pipe_ff[g-1];
            if (pipe_ff[g-1].big) begin
               nx.az = 34'h2_0000_0000;
            end
         end
      end else if (g == ST_SQ) begin : g_sq
         always_comb begin
            nx      = pipe_ff[g-1];
            // at 7.0 and above the exponent argument is already past 24
            nx.ez   = pipe_ff[g-1].az >= 34'd7516192768;
            nx.prod = 66'(pipe_ff[g-1].az[32:0]) * 66'(pipe_ff[g-1].az[32:0]);
         end
      end else if (g == ST_EXARG) begin : g_exarg
         always_comb begin
            nx    = pipe_ff[g-1];
            nx.ex = pipe_ff[g-1].prod[65:31];
            nx.ez = pipe_ff[g-1].ez || (pipe_ff[g-1].prod[65:31] >= 35'd25769803776);
         end
      end else if (g == ST_LOGMUL) begin : g_logmul
         always_comb begin
            nx      = pipe_ff[g-1];
            nx.prod = 66'(pipe_ff[g-1].ex[29:0]) * 66'(gpacq_pkg::K_LOG2E);
         end
      end else if (g == ST_LOGSUM) begin : g_logsum
         always_comb begin
            logic [35:0] u;
            nx   = pipe_ff[g-1];
            u    = 36'(pipe_ff[g-1].ex[34:30]) * 36'(gpacq_pkg::K_LOG2E)
                 + 36'(pipe_ff[g-1].prod[60:30]);
            nx.n = u[35:30];
            nx.y = u[29:0];
         end
      end else if (g == ST_LNMUL) begin : g_lnmul
         always_comb begin
            nx      = pipe_ff[g-1];
            nx.prod = 66'(pipe_ff[g-1].y) * 66'(gpacq_pkg::K_LN2);
         end
      end else if (g == ST_Y) begin : g_y
         always_comb begin
            nx   = pipe_ff[g-1];
            nx.y = pipe_ff[g-1].prod[59:30];
            nx.r = gpacq_pkg::Q30_ONE;
         end
      end else if (g >= HORN_LO && g < ST_SHIFT) begin : g_horn
         localparam int unsigned K = 9 - (g - HORN_LO) / 2;
         if (((g - HORN_LO) % 2) == 0) begin : g_mul
            always_comb begin
               nx      = pipe_ff[g-1];
               nx.prod = 66'(pipe_ff[g-1].y) * 66'(pipe_ff[g-1].r);
            end
         end else begin : g_div
            always_comb begin
               nx   = pipe_ff[g-1];
               nx.r = gpacq_pkg::Q30_ONE
                    - 31'(gpacq_pkg::div_small(pipe_ff[g-1].prod[59:30], K));
            end
         end
      end else if (g == ST_SHIFT) begin : g_shift
         always_comb begin
            nx   = pipe_ff[g-1];
            nx.r = pipe_ff[g-1].ez ? 31'd0 : (pipe_ff[g-1].r >> pipe_ff[g-1].n);
         end
      end else if (g == ST_PDFMUL) begin : g_pdfmul
         always_comb begin
            nx      = pipe_ff[g-1];
            nx.prod = 66'(pipe_ff[g-1].r) * 66'(gpacq_pkg::K_INV_SQRT_2PI);
         end
      end else if (g == ST_PDF) begin : g_pdf
         always_comb begin
            nx      = pipe_ff[g-1];
            nx.pd   = pipe_ff[g-1].prod[58:30];
            nx.prod = 66'(pipe_ff[g-1].az[29:0]) * 66'(gpacq_pkg::K_P);
         end
      end else if (g == ST_DEN) begin : g_den
         always_comb begin
            nx     = pipe_ff[g-1];
            nx.den = 32'(gpacq_pkg::Q30_ONE)
                   + 32'(pipe_ff[g-1].az[33:30]) * 32'(gpacq_pkg::K_P)
                   + 32'(pipe_ff[g-1].prod[57:30]);
            nx.rem = 33'h0_2000_0000;
            nx.t   = '0;
         end
      end else if (g >= DIVT_LO && g < ST_PINIT) begin : g_divt
         localparam int BIT = 30 - (g - DIVT_LO);
         always_comb begin
            logic [32:0] trial;
            nx    = pipe_ff[g-1];
            trial = {pipe_ff[g-1].rem[31:0], 1'b0};
            if (trial >= {1'b0, pipe_ff[g-1].den}) begin
               nx.rem    = trial - {1'b0, pipe_ff[g-1].den};
               nx.t[BIT] = 1'b1;
            end else begin
               nx.rem = trial;
            end
         end
      end else if (g == ST_PINIT) begin : g_pinit
         always_comb begin
            nx   = pipe_ff[g-1];
            nx.s = gpacq_pkg::K_B5;
         end
      end else if (g >= POLY_LO && g < ST_CDFMUL) begin : g_poly
         localparam int J = (g - POLY_LO) / 2;
         if (((g - POLY_LO) % 2) == 0) begin : g_mul
            always_comb begin
               logic [33:0] m;
               nx      = pipe_ff[g-1];
               m       = pipe_ff[g-1].s[33] ? 34'(-pipe_ff[g-1].s) : 34'(pipe_ff[g-1].s);
               nx.prod = 66'(m) * 66'(pipe_ff[g-1].t);
            end
         end else begin : g_acc
            always_comb begin
               logic signed [33:0] mag;
               nx   = pipe_ff[g-1];
               mag  = $signed(pipe_ff[g-1].prod[63:30]);
               nx.s = (pipe_ff[g-1].s[33] ? -mag : mag) + gpacq_pkg::POLY_B[J];
            end
         end
      end else if (g == ST_CDFMUL) begin : g_cdfmul
         always_comb begin
            logic [32:0] sc;
            nx      = pipe_ff[g-1];
            sc      = pipe_ff[g-1].s[33] ? 33'd0 : pipe_ff[g-1].s[32:0];
            nx.prod = 66'(pipe_ff[g-1].pd) * 66'(sc);
         end
      end else if (g == ST_CDF) begin : g_cdf
         always_comb begin
            logic [35:0] qv;
            logic [30:0] q;
            nx   = pipe_ff[g-1];
            qv   = pipe_ff[g-1].prod[65:30];
            q    = (qv > 36'(gpacq_pkg::Q30_ONE)) ? gpacq_pkg::Q30_ONE : qv[30:0];
            nx.c = pipe_ff[g-1].neg ? q : gpacq_pkg::Q30_ONE - q;
         end
      end else if (g == ST_EIMUL) begin : g_eimul
         always_comb begin
            nx      = pipe_ff[g-1];
            nx.prod = 66'(pipe_ff[g-1].ad) * 66'(pipe_ff[g-1].c);
            nx.aux  = 64'(pipe_ff[g-1].sg) * 64'(pipe_ff[g-1].pd);
         end
      end else begin : g_eisum
         always_comb begin
            logic signed [64:0] dc;
            logic signed [64:0] sp;
            logic signed [64:0] sm;
            nx = pipe_ff[g-1];
            dc = $signed(65'(pipe_ff[g-1].prod[62:0]));
            sp = $signed(65'(pipe_ff[g-1].aux));
            sm = pipe_ff[g-1].neg ? sp - dc : sp + dc;
            // negative EI from approximation error clamps to zero
            nx.prod = sm[64] ? 66'd0 : 66'(sm[63:0]);
         end
      end
   end

   // ---------------- output: mode select, rounding, saturation ----------------
   always_comb begin
      logic [64:0]        ei;
      logic signed [33:0] uc;
      logic [31:0]        pv;
      gpacq_pkg::pipe_type p;
      p  = pipe_ff[NST-1];
      ei = 65'(p.prod[63:0]) + 65'h0_2000_0000;
      uc = {{2{p.mu[31]}}, p.mu} + $signed({2'b00, p.sg, 1'b0});
      pv = (32'(p.c) + (32'd1 << (SH - 1))) >> SH;
      rsp_in.saturated = 1'b0;
      rsp_in.score     = p.mu;
      if (p.zero) begin
         rsp_in.score     = p.gt ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         rsp_in.saturated = 1'b1;
      end else begin
         unique case (p.mode)
            gpacq_pkg::MODE_MEAN: rsp_in.score = p.mu;
            gpacq_pkg::MODE_PI:   rsp_in.score = $signed(pv);
            gpacq_pkg::MODE_UCB: begin
               if (uc > 34'sh0_7FFF_FFFF) begin
                  rsp_in.score     = 32'sh7FFF_FFFF;
                  rsp_in.saturated = 1'b1;
               end else if (uc < -34'sh0_8000_0000) begin
                  rsp_in.score     = 32'sh8000_0000;
                  rsp_in.saturated = 1'b1;
               end else begin
                  rsp_in.score = uc[31:0];
               end
            end
            gpacq_pkg::MODE_EI: begin
               if (ei[64:30] > 35'h0_7FFF_FFFF) begin
                  rsp_in.score     = 32'sh7FFF_FFFF;
                  rsp_in.saturated = 1'b1;
               end else begin
                  rsp_in.score = $signed(ei[61:30]);
               end
            end
            default: rsp_in.score = p.mu;
         endcase
      end
   end

   assign rsp_valid_in = adv ? vld_ff[NST-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            vld_ff <= vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/gpacq_chk.sv
module gpacq_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input gpacq_pkg::rsp_type rsp_data
);

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // input side never blocks while the output side can move
   a_ready_follows: assert property (@(posedge clock)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("req_ready low while output free");

   // stalled result holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // a stall on the output blocks the input
   a_stall_blocks: assert property (@(posedge clock)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken during output stall");

endmodule

bind gp_acquisition_score_top gpacq_chk u_gpacq_chk (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned MASK_Q30 = ONE_Q30 - 1;
   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -64'sd2147483648;
   // APB byte addresses
   localparam logic [2:0] ADDR_MODE = 3'd0;
   localparam logic [2:0] ADDR_UNUSED = 3'd4;
   // pipe depth, with margin
   localparam int PIPE_CYCLES = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   gpacq_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   gpacq_pkg::rsp_type rsp_data;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // items waiting to be offered, and scores waiting for their transfer
   gpacq_pkg::req_type  pending_reqs[$];
   gpacq_pkg::rsp_type  score_queue[$];
   gpacq_pkg::mode_type cur_mode = gpacq_pkg::MODE_EI;
   logic                req_taken = 1'b0;
   int                  fail_count = 0;

   gp_acquisition_score_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Fixed-point scorer model
   // ---------------------------------------------------------------
   function automatic longint unsigned q30_mul(longint unsigned x, longint unsigned y);
      return (x >> 30) * y + (((x & MASK_Q30) * y) >> 30);
   endfunction

   // signed Q30 times unsigned Q30, truncated toward zero
   function automatic longint q30_smul(longint s, longint unsigned t);
      longint unsigned m;
      longint unsigned r;
      m = (s < 0) ? longint'(-s) : longint'(s);
      r = (m * t) >> 30;
      return (s < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint unsigned exp_neg(longint unsigned x);
      longint unsigned u, f, y, r;
      int n;
      if (x >= (64'd24 << 30)) return 0;
      u = q30_mul(x, 64'd1549082005);
      n = int'(u >> 30);
      f = u & MASK_Q30;
      y = (f * 64'd744261118) >> 30;
      r = ONE_Q30;
      for (int k = 9; k >= 1; k--) r = ONE_Q30 - ((y * r) >> 30) / longint'(k);
      return r >> n;
   endfunction

   function automatic longint unsigned gauss_density(longint unsigned az);
      return q30_mul(exp_neg(q30_mul(az, az) >> 1), 64'd428361012);
   endfunction

   function automatic longint unsigned normal_cdf(longint unsigned az, longint unsigned pd,
                                                  bit neg);
      longint unsigned den, t, q;
      longint s;
      den = ONE_Q30 + q30_mul(az, 64'd248723606);
      t = (ONE_Q30 << 30) / den;
      s = 64'sd1428371291;
      s = -64'sd1955558716 + q30_smul(s, t);
      s = 64'sd1912847370 + q30_smul(s, t);
      s = -64'sd382857446 + q30_smul(s, t);
      s = 64'sd342933308 + q30_smul(s, t);
      s = q30_smul(s, t);
      if (s < 0) s = 0;
      q = (pd * longint'(s)) >> 30;
      if (q > ONE_Q30) q = ONE_Q30;
      return neg ? q : ONE_Q30 - q;
   endfunction

   function automatic gpacq_pkg::rsp_type acq_score(gpacq_pkg::mode_type mode,
                                                    gpacq_pkg::req_type r);
      gpacq_pkg::rsp_type res;
      longint mu, best, d, v, dc, sum;
      longint unsigned sg, ad, az, pd, c;
      bit neg, flag;
      mu = longint'(r.pred_mean);
      best = longint'(r.best_value);
      sg = longint'(r.pred_stddev);
      flag = 1'b0;
      if (sg == 0) begin
         v = (mu > best) ? S32_HI : S32_LO;
         flag = 1'b1;
      end else if (mode == gpacq_pkg::MODE_MEAN) begin
         v = mu;
      end else if (mode == gpacq_pkg::MODE_UCB) begin
         v = mu + 2 * longint'(sg);
      end else begin
         d = mu - best;
         neg = d < 0;
         ad = neg ? longint'(-d) : longint'(d);
         if (ad >= 8 * sg) az = 64'd8 << 30;
         else az = (ad << 30) / sg;
         pd = gauss_density(az);
         c = normal_cdf(az, pd, neg);
         if (mode == gpacq_pkg::MODE_PI) begin
            v = longint'((c + (64'd1 << 13)) >> 14);
         end else begin
            dc = longint'(ad * c);
            sum = (neg ? -dc : dc) + longint'(sg * pd);
            if (sum < 0) sum = 0;
            v = longint'((longint'(sum) + (64'd1 << 29)) >> 30);
         end
      end
      if (v > S32_HI) begin
         v = S32_HI;
         flag = 1'b1;
      end else if (v < S32_LO) begin
         v = S32_LO;
         flag = 1'b1;
      end
      res.score = v[31:0];
      res.saturated = flag;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic void queue_req(gpacq_pkg::req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic logic [31:0] rand_word();
      logic [31:0] w;
      w = $urandom >> $urandom_range(0, 31);
      return ($urandom_range(0, 1) != 0) ? -w : w;
   endfunction

   function automatic gpacq_pkg::req_type rand_req();
      gpacq_pkg::req_type r;
      logic [31:0] off;
      int pick;
      pick = $urandom_range(0, 19);
      r.pred_mean = rand_word();
      if (pick == 0) r.pred_stddev = '0;
      else if (pick == 1) r.pred_stddev = 31'($urandom);
      else r.pred_stddev = 31'($urandom >> $urandom_range(1, 31));
      if (pick < 4) begin
         r.best_value = rand_word();
      end else begin
         // offset near sigma so z lands in the interesting range
         off = 32'(r.pred_stddev) >> $urandom_range(0, 6);
         off = off * $urandom_range(0, 9);
         if ($urandom_range(0, 1) != 0) off = -off;
         r.best_value = r.pred_mean - off;
      end
      return r;
   endfunction

   function automatic gpacq_pkg::req_type mk_req(logic [31:0] mu, logic [30:0] sg,
                                                 logic [31:0] bv);
      gpacq_pkg::req_type r;
      r.pred_mean = mu;
      r.pred_stddev = sg;
      r.best_value = bv;
      return r;
   endfunction

   task automatic apb_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_MODE) cur_mode = gpacq_pkg::mode_type'(data[1:0]);
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (score_queue.size() == 0);
      repeat (PIPE_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // Sender: offers the next pending item at the falling edge
   // ---------------------------------------------------------------
   int  req_gap = 0;
   int  req_burst = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold valid and payload until the transfer
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
         req_data <= pending_reqs.pop_front();
         req_valid <= 1'b1;
         if (req_burst > 0) begin
            req_burst <= req_burst - 1;
            req_gap <= 0;
         end else if ($urandom_range(0, 99) == 0) begin
            req_burst <= $urandom_range(20, 80);   // back-to-back stretch
            req_gap <= 0;
         end else if ($urandom_range(0, 9) < 8) begin
            req_gap <= $urandom_range(0, 2);
         end else begin
            req_gap <= $urandom_range(5, 40);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off that fills the pipe
   // ---------------------------------------------------------------
   int rsp_gap = 0;
   int rsp_cycle = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_cycle <= rsp_cycle + 1;
         // long hold-off once, while plenty of items are still queued
         if (!hold_done && rsp_cycle >= 3000 && pending_reqs.size() > 100) begin
            hold_done <= 1'b1;
            hold_left <= 600;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ((rsp_cycle / 500) % 4 == 1) rsp_gap <= 0;   // no stalls here
            else if ($urandom_range(0, 9) < 8) rsp_gap <= $urandom_range(0, 2);
            else rsp_gap <= $urandom_range(5, 40);
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predicts on each input transfer, checks each result transfer
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      gpacq_pkg::rsp_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) begin
            score_queue.insert(score_queue.size(), acq_score(cur_mode, req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (score_queue.size() == 0) begin
               $error("result transfer with no score expected");
               fail_count++;
            end else begin
               want = score_queue.pop_front();
               if (rsp_data.score !== want.score) begin
                  $error("score: expected %0d, got %0d", want.score, rsp_data.score);
                  fail_count++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated,
                         rsp_data.saturated);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Test sequence: one phase per mode setting
   // ---------------------------------------------------------------
   gpacq_pkg::mode_type phase_modes[7] = '{gpacq_pkg::MODE_EI, gpacq_pkg::MODE_UCB,
                                           gpacq_pkg::MODE_PI, gpacq_pkg::MODE_MEAN,
                                           gpacq_pkg::MODE_PI, gpacq_pkg::MODE_EI,
                                           gpacq_pkg::MODE_UCB};
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 7; p++) begin
         apb_write(ADDR_MODE, 32'(phase_modes[p]));
         if (p == 3) apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);   // must be ignored
         // corner items: zero sigma both ways and equal, extremes of each field
         queue_req(mk_req(32'sd100, 31'd0, 32'sd50));
         queue_req(mk_req(32'sd50, 31'd0, 32'sd50));
         queue_req(mk_req(32'h8000_0000, 31'd0, 32'h7FFF_FFFF));
         queue_req(mk_req(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000));
         queue_req(mk_req(32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF));
         queue_req(mk_req(32'h7FFF_FFFF, 31'd1, 32'h8000_0000));
         queue_req(mk_req(32'h0001_0000, 31'h0001_0000, 32'h0001_0000));
         queue_req(mk_req(32'hFFFF_FFFF, 31'd1, 32'h0000_0000));
         for (int i = 0; i < 200; i++) queue_req(rand_req());
         drain();
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
